// File: design/crps_pkg.sv
// Package: shared constants, types and the weight table for the polyline smoother.
`timescale 1ns / 1ps
`default_nettype none
package crps_pkg;
  localparam int SmoothMax  = 16;
  localparam int CoordWidth = 32;
  localparam int CfgWidth   = 5;
  localparam int SW         = $clog2(SmoothMax + 1);
  localparam int IdxW       = $clog2(SmoothMax);  // table index bits per field (S-1 and s)
  localparam int WW         = 19;            // Q2.16 weight, signed
  localparam int AxisCount  = 3;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [WW-1:0]         weight_t;
  typedef logic [SW-1:0]                step_t;

  typedef struct packed {
    weight_t w0;
    weight_t w1;
    weight_t w2;
    weight_t w3;
  } wset_t;

  // weight sets indexed by {S-1, s}
  typedef wset_t [(1 << (2 * IdxW))-1:0] wtab_t;

  typedef struct packed {
    logic run_last;
    logic line_last;
  } mark_t;

  // Floor division by shift and subtract, for table values only (den > 0).
  function automatic logic signed [63:0] fdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    logic signed [63:0] mag, q, r;
    logic neg;
    neg = num < 0;
    mag = neg ? -num : num;
    q = '0;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      r = {r[62:0], mag[b]};
      q = {q[62:0], 1'b0};
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if (neg) begin
      q = -q;
      if (r != 0) q = q - 64'sd1;
    end
    return q;
  endfunction

  // Basis weights at t = s/S, rounded half up to Q2.16.
  function automatic wset_t weights(input step_t s, input step_t sf);
    logic signed [63:0] s1, s2, s3, f1, f2, f3, n0, n1, n2, n3, d;
    wset_t r;
    s1 = 64'(s);
    f1 = 64'(sf);
    s2 = s1 * s1;
    s3 = s2 * s1;
    f2 = f1 * f1;
    f3 = f2 * f1;
    n0 = -s3 + 2 * s2 * f1 - s1 * f2;
    n1 = 3 * s3 - 5 * s2 * f1 + 2 * f3;
    n2 = -3 * s3 + 4 * s2 * f1 + s1 * f2;
    n3 = s3 - s2 * f1;
    d  = 2 * f3;
    if (d == 0) d = 1;
    r.w0 = WW'(fdiv(n0 * 65536 + f3, d));
    r.w1 = WW'(fdiv(n1 * 65536 + f3, d));
    r.w2 = WW'(fdiv(n2 * 65536 + f3, d));
    r.w3 = WW'(fdiv(n3 * 65536 + f3, d));
    return r;
  endfunction

  function automatic wtab_t build_wtab();
    wtab_t t;
    t = '0;
    for (int i = 0; i < SmoothMax; i++)
      for (int j = 0; j < SmoothMax; j++)
        t[(i << IdxW) | j] = weights(step_t'(j), step_t'(i + 1));
    return t;
  endfunction

  localparam wtab_t WTab = build_wtab();
endpackage
`default_nettype wire

// File: design/crps_lane.sv
// Module: one axis lane: four products, registered, then summed and saturated.
`timescale 1ns / 1ps
`default_nettype none
module crps_lane
  import crps_pkg::*;
(
  input  wire        clk,
  input  wire        en,
  input  coord_t     c0,
  input  coord_t     c1,
  input  coord_t     c2,
  input  coord_t     c3,
  input  wset_t      w,
  output coord_t     res
);
  localparam int PW = CoordWidth + WW;
  logic signed [PW-1:0] p0, p1, p2, p3;
  logic signed [PW+1:0] sum;
  logic signed [PW+1:0] rnd;
  logic signed [PW+1:0] hi, lo;

  always_ff @(posedge clk) begin
    if (en) begin
      p0 <= PW'(c0 * w.w0);
      p1 <= PW'(c1 * w.w1);
      p2 <= PW'(c2 * w.w2);
      p3 <= PW'(c3 * w.w3);
    end
  end

  always_comb begin
    sum = (PW+2)'(p0) + (PW+2)'(p1) + (PW+2)'(p2) + (PW+2)'(p3);
    rnd = (sum + (PW+2)'(32768)) >>> 16;
    hi  = (PW+2)'({1'b0, {(CoordWidth-1){1'b1}}});
    lo  = -hi - (PW+2)'(1);
    if (rnd > hi)      res = coord_t'(hi);
    else if (rnd < lo) res = coord_t'(lo);
    else               res = coord_t'(rnd);
  end
endmodule
`default_nettype wire

// File: design/catmull_rom_polyline_smoother_top.sv
// Top level: Catmull-Rom polyline smoother with three axis lanes and output stage.
`timescale 1ns / 1ps
`default_nettype none
// Points come in one transaction at a time and the last three points of the
// current line are kept. With smooth_factor S of 2 or more, from the fourth
// point of a line on, each point yields S interpolated points, one per cycle
// while the output is not stalled; the three axes run in three parallel lanes
// (one multiply stage, one add/round/saturate stage) and are merged into one
// output transaction. S = 1 passes points through, and a short line is
// replayed unchanged at its end, one point per cycle while the output is not
// stalled. The next point is accepted only in the idle state with stage one
// empty, once the output register is empty or its result is being taken.
module catmull_rom_polyline_smoother_top
  import crps_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_wr_en,
  input  wire  [4:0]  cfg_wr_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [95:0] s_axis_tdata,   // point_x, point_y, point_z
  input  wire         s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z
  output logic        m_axis_tlast,   // line_last
  output logic        m_axis_tuser    // run_last
);
  typedef enum logic [1:0] {IDLE, INTERP, REPLAY} state_t;
  state_t state;
  logic [CfgWidth-1:0] smooth_factor;
  coord_t win [9];
  coord_t cur [3];
  logic [1:0] points_seen;
  logic end_f;
  step_t sf, step;
  logic [1:0] rk;
  // pipeline: stage1 valid/marks, stage2 is the output register
  logic v1;
  mark_t m1;
  logic pass1;
  coord_t pc [3];
  wset_t wt;
  coord_t lr [3];
  logic acc, out_free;
  logic issue;   // stage1 takes a new result this cycle

  always_comb begin
    if (smooth_factor == '0) sf = step_t'(1);
    else if (32'(smooth_factor) > SmoothMax) sf = step_t'(SmoothMax);
    else sf = step_t'(smooth_factor);
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == IDLE) && !v1 && out_free;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign wt = WTab[{IdxW'(sf - step_t'(1)), IdxW'(step)}];
  assign issue = ((state == IDLE) && acc && (sf == step_t'(1)))
              || (((state == INTERP) || (state == REPLAY)) && out_free);

  for (genvar a = 0; a < AxisCount; a++) begin : g_lane
    crps_lane u_lane (
      .clk(clk), .en(out_free),
      .c0(win[a]), .c1(win[3+a]), .c2(win[6+a]), .c3(cur[a]),
      .w(wt), .res(lr[a]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; smooth_factor <= CfgWidth'(1); points_seen <= '0;
      v1 <= 1'b0; m_axis_tvalid <= 1'b0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      if (cfg_wr_en) smooth_factor <= cfg_wr_data;
      if (out_free) begin
        m_axis_tvalid <= v1;
        if (v1) begin
          m_axis_tuser  <= m1.run_last;
          m_axis_tlast  <= m1.line_last;
          m_axis_tdata  <= pass1 ? {pc[2], pc[1], pc[0]} : {lr[2], lr[1], lr[0]};
        end
        v1 <= issue;
      end
      unique case (state)
        IDLE: begin
          if (acc) begin
            cur[0] <= s_axis_tdata[31:0];
            cur[1] <= s_axis_tdata[63:32];
            cur[2] <= s_axis_tdata[95:64];
            end_f <= s_axis_tlast;
            step <= '0;
            if (sf == step_t'(1)) begin
              pass1 <= 1'b1;
              pc[0] <= s_axis_tdata[31:0];
              pc[1] <= s_axis_tdata[63:32];
              pc[2] <= s_axis_tdata[95:64];
              m1 <= '{run_last: 1'b1, line_last: s_axis_tlast};
              for (int i = 0; i < 6; i++) win[i] <= win[i+3];
              win[6] <= s_axis_tdata[31:0];
              win[7] <= s_axis_tdata[63:32];
              win[8] <= s_axis_tdata[95:64];
              points_seen <= s_axis_tlast ? 2'd0
                           : (points_seen == 2'd3 ? 2'd3 : points_seen + 2'd1);
            end else if (points_seen == 2'd3) begin
              state <= INTERP;
            end else if (s_axis_tlast) begin
              rk <= 2'd3 - points_seen;
              state <= REPLAY;
            end else begin
              for (int i = 0; i < 6; i++) win[i] <= win[i+3];
              win[6] <= s_axis_tdata[31:0];
              win[7] <= s_axis_tdata[63:32];
              win[8] <= s_axis_tdata[95:64];
              points_seen <= points_seen + 2'd1;
            end
          end
        end
        INTERP: begin
          if (out_free) begin
            pass1 <= 1'b0;
            m1 <= '{run_last: step == sf - step_t'(1),
                    line_last: end_f && (step == sf - step_t'(1))};
            step <= step + step_t'(1);
            if (step == sf - step_t'(1)) begin
              state <= IDLE;
              for (int i = 0; i < 6; i++) win[i] <= win[i+3];
              for (int a = 0; a < 3; a++) win[6+a] <= cur[a];
              points_seen <= end_f ? 2'd0 : 2'd3;
            end
          end
        end
        REPLAY: begin
          if (out_free) begin
            pass1 <= 1'b1;
            if (rk == 2'd3) begin
              pc <= cur;
              m1 <= '{run_last: 1'b1, line_last: 1'b1};
              state <= IDLE;
              for (int i = 0; i < 6; i++) win[i] <= win[i+3];
              for (int a = 0; a < 3; a++) win[6+a] <= cur[a];
              points_seen <= 2'd0;
            end else begin
              for (int a = 0; a < 3; a++) pc[a] <= win[3*rk+a];
              m1 <= '{run_last: 1'b0, line_last: 1'b0};
              rk <= rk + 2'd1;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser) else $error("line_last without run_last");
  a_seen: assert property (@(posedge clk) disable iff (rst)
    (state == INTERP) |-> (points_seen == 2'd3)) else $error("interp without window");
`endif
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the Catmull-Rom polyline smoother: stream stimulus and result checking.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import crps_pkg::*;

  // Slack after the last expected result, for trailing work.
  localparam int DrainCycles = 40;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     run_last;
    bit     line_last;
  } vertex_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // point_x, point_y, point_z
  logic        s_axis_tlast;   // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // out_x, out_y, out_z
  logic        m_axis_tlast;   // line_last
  logic        m_axis_tuser;   // run_last

  catmull_rom_polyline_smoother_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  // Predictor state: copy of the point window, held-point count and register.
  coord_t  hist[9];
  int      held;
  int      smooth_reg;
  vertex_t spline_q[$];   // expected output points, oldest first
  int      mismatches;
  bit      no_idle;       // final stretch runs without gaps or stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5ms;
    $display("tb: FAIL");
    $finish;
  end

  // Exact basis weight k at t = s/S, rounded half up to Q2.16.
  function automatic longint basis_q16(longint s, longint sf, int k);
    longint s2, s3, f2, f3, num, n, d;
    s2 = s * s;
    s3 = s2 * s;
    f2 = sf * sf;
    f3 = f2 * sf;
    case (k)
      0:       num = -s3 + 2 * s2 * sf - s * f2;
      1:       num = 3 * s3 - 5 * s2 * sf + 2 * f3;
      2:       num = -3 * s3 + 4 * s2 * sf + s * f2;
      default: num = s3 - s2 * sf;
    endcase
    n = num * 65536 + f3;
    d = 2 * f3;
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh80000000) * -1) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  function automatic vertex_t make_vertex(coord_t x, coord_t y, coord_t z, bit rl, bit ll);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.run_last = rl;
    v.line_last = ll;
    return v;
  endfunction

  // Expected outputs for one accepted point; updates the window afterward.
  task automatic predict_spline(coord_t px, coord_t py, coord_t pz, bit line_end);
    int     sf;
    longint w[4];
    longint acc;
    coord_t cur[3];
    coord_t res[3];
    cur[0] = px;
    cur[1] = py;
    cur[2] = pz;
    sf = smooth_reg;
    if (sf == 0) sf = 1;
    if (sf > SmoothMax) sf = SmoothMax;
    if (sf == 1) begin
      spline_q.push_back(make_vertex(px, py, pz, 1'b1, line_end));
    end else if (held >= 3) begin
      for (int s = 0; s < sf; s++) begin
        for (int k = 0; k < 4; k++) w[k] = basis_q16(s, sf, k);
        for (int a = 0; a < 3; a++) begin
          acc = longint'(hist[a]) * w[0] + longint'(hist[3 + a]) * w[1]
              + longint'(hist[6 + a]) * w[2] + longint'(cur[a]) * w[3];
          res[a] = clamp_coord((acc + 32768) >>> 16);
        end
        spline_q.push_back(make_vertex(res[0], res[1], res[2], s == sf - 1,
                                       line_end && (s == sf - 1)));
      end
    end else if (line_end) begin
      // short line: replay held points, then the current one
      for (int k = 3 - held; k < 3; k++)
        spline_q.push_back(make_vertex(hist[3 * k], hist[3 * k + 1], hist[3 * k + 2], 0, 0));
      spline_q.push_back(make_vertex(px, py, pz, 1'b1, 1'b1));
    end
    for (int a = 0; a < 6; a++) hist[a] = hist[a + 3];
    for (int a = 0; a < 3; a++) hist[6 + a] = cur[a];
    if (held < 3) held++;
    if (line_end) held = 0;
  endtask

  // Send one point transaction, with an optional random gap before it.
  task automatic send_point(coord_t px, coord_t py, coord_t pz, bit line_end);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pz, py, px};
    s_axis_tlast  <= line_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_spline(px, py, pz, line_end);
  endtask

  // Drain all expected points, then allow for trailing no-result work.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (spline_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_smooth(logic [4:0] value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    smooth_reg = value;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0:       return coord_t'($urandom);
      1:       return coord_t'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      2:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
    endcase
  endfunction

  task automatic send_line(int len);
    for (int i = 0; i < len; i++)
      send_point(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
  endtask

  // Reset value of the register is pass-through.
  task automatic test_passthrough();
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh0, 1'b0);
    send_point(32'sh00010000, -32'sh00010000, 32'sh12345678, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, -32'sh1, 1'b0);
    send_point(32'sh0, 32'sh0, 32'sh7fffffff, 1'b1);
  endtask

  // Lines of one, two and three points replay unchanged at their end.
  task automatic test_short_lines();
    write_smooth(5'd4);
    send_line(1);
    send_line(2);
    send_line(3);
  endtask

  // Alternating extremes overshoot the range and must saturate.
  task automatic test_saturation();
    write_smooth(5'd16);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh0, 1'b0);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 1'b0);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    send_point(32'sh00008000, -32'sh00008000, 32'sh1, 1'b1);
  endtask

  // Zero acts as 1, values above the maximum clamp to it.
  task automatic test_factor_limits();
    write_smooth(5'd0);
    send_line(5);
    write_smooth(5'd31);
    send_line(5);
    write_smooth(5'd2);
    send_line(4);
    // history survives a switch from pass-through to smoothing
    write_smooth(5'd1);
    send_point(32'sh10000, 32'sh20000, 32'sh30000, 1'b0);
    send_point(32'sh40000, 32'sh50000, 32'sh60000, 1'b0);
    send_point(32'sh70000, 32'sh80000, 32'sh90000, 1'b0);
    write_smooth(5'd3);
    send_point(32'sha0000, 32'shb0000, 32'shc0000, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int len;
    logic [4:0] sf;
    sent = 0;
    while (sent < 300) begin
      if (sent >= 250 && !no_idle) begin
        wait_idle();
        no_idle = 1'b1;
      end
      sf = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(1, 6));
      write_smooth(sf);
      for (int l = 0; l < 4; l++) begin
        // mostly full lines, some short ones as noise
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 9);
        send_line(len);
        sent += len;
      end
    end
  endtask

  // Result stall generator on the output side.
  int stall_left;
  always @(posedge clk) begin
    if (rst || no_idle) begin
      m_axis_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each output transaction with the oldest expected point.
  always @(posedge clk) begin
    vertex_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (spline_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: x=%h y=%h z=%h", m_axis_tdata[31:0],
                   m_axis_tdata[63:32], m_axis_tdata[95:64]);
      end else begin
        e = spline_q.pop_front();
        if (m_axis_tdata !== {e.z, e.y, e.x} || m_axis_tuser !== e.run_last ||
            m_axis_tlast !== e.line_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp x=%h y=%h z=%h rl=%b ll=%b got x=%h y=%h z=%h rl=%b ll=%b",
                     e.x, e.y, e.z, e.run_last, e.line_last, m_axis_tdata[31:0],
                     m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 5'd0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    mismatches = 0;
    no_idle = 1'b0;
    held = 0;
    smooth_reg = 1;
    foreach (hist[i]) hist[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_passthrough();
    test_short_lines();
    test_saturation();
    test_factor_limits();
    test_random();
    wait_idle();
    if (mismatches == 0 && spline_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
